[hw/rtl/bdq_pkg.sv]
// shared field widths, request kinds and status codes for the bounded deque
package bdq_pkg;

  localparam int KIND_W   = 3;
  localparam int VALUE_W  = 32;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 2;
  localparam int FOUND_W  = 4;
  localparam int LEN_W    = 5;

  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 3'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_BACK  = 3'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_POP_BACK   = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIND       = 3'd4;
  localparam logic [KIND_W-1:0] KIND_READ_AT    = 3'd5;
  localparam logic [KIND_W-1:0] KIND_REMOVE_AT  = 3'd6;

  localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_RANGE = 2'd3;

endpackage

[hw/rtl/bounded_deque_with_search.sv]
// bounded deque over a ring store, with find, read at and remove at position
// push writes in S_EXEC; pop and read at read in S_EXEC and take the data in S_RDATA;
// find compares entries in S_SCAN; remove at moves the entries behind the removed one in
// S_SHIFT, one entry moved per cycle; the store port pair and one slot adder set the pace
// a new request may be accepted while the previous result still waits
// reset clears front pointer, count and handshake state; store contents stay undefined
module bounded_deque_with_search
  import bdq_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int VALUE_BITS = 32
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [KIND_W-1:0]          kind,
  input  logic signed [VALUE_W-1:0]  value,
  input  logic [POS_W-1:0]           position,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic [STATUS_W-1:0]        status,
  output logic signed [VALUE_W-1:0]  data_out,
  output logic [FOUND_W-1:0]         found_at,
  output logic [LEN_W-1:0]           length
);

  localparam int IW  = $clog2(CAPACITY);
  localparam int CW  = $clog2(CAPACITY + 1);
  localparam int SW  = CW + 1;
  localparam int PCW = (CW > POS_W) ? CW : POS_W;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_RDATA = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_RMV0  = 3'd4;
  localparam logic [2:0] S_SHIFT = 3'd5;
  localparam logic [2:0] S_DONE  = 3'd6;

  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] f, input logic [CW-1:0] o);
    logic [SW-1:0] s;
    s = SW'(f) + SW'(o);
    if (s >= SW'(CAPACITY)) begin
      s = s - SW'(CAPACITY);
    end
    return s[IW-1:0];
  endfunction

  function automatic logic [VALUE_W-1:0] to_out(input logic [VALUE_BITS-1:0] s);
    logic signed [63:0] w;
    w = 64'(signed'(s));
    return w[VALUE_W-1:0];
  endfunction

  logic [2:0]            state, state_next;
  logic [IW-1:0]         front, front_next;
  logic [CW-1:0]         count, count_next;
  logic [KIND_W-1:0]     req_kind;
  logic [VALUE_BITS-1:0] req_key;
  logic [POS_W-1:0]      req_pos;
  logic [CW-1:0]         idx, idx_next;
  logic [IW-1:0]         hold_addr, hold_addr_next;
  logic [IW-1:0]         rd_addr_q;
  logic [STATUS_W-1:0]   res_status, res_status_next;
  logic [VALUE_W-1:0]    res_data, res_data_next;
  logic [FOUND_W-1:0]    res_found, res_found_next;

  logic                  wr_en, rd_en;
  logic [IW-1:0]         wr_addr, slot;
  logic [VALUE_BITS-1:0] wr_data, rd_data;
  logic [CW-1:0]         off;
  logic [CW-1:0]         idx_p1, idx_p2;
  logic [IW-1:0]         front_inc, front_dec;
  logic                  is_full, is_empty, pos_out;
  logic                  in_fire, out_load;
  logic signed [63:0]    value_wide;

  assign in_ready   = (state == S_IDLE);
  assign in_fire    = in_valid && in_ready;
  assign out_load   = (state == S_DONE) && (!out_valid || out_ready);
  assign value_wide = 64'(value);

  assign idx_p1    = idx + CW'(1);
  assign idx_p2    = idx + CW'(2);
  assign front_inc = (front == IW'(CAPACITY - 1)) ? '0 : front + IW'(1);
  assign front_dec = (front == '0) ? IW'(CAPACITY - 1) : front - IW'(1);
  assign is_full   = (count == CW'(CAPACITY));
  assign is_empty  = (count == '0);
  assign pos_out   = (PCW'(req_pos) >= PCW'(count));

  // offset from the front fed to the one slot adder
  always_comb begin
    off = '0;
    case (state)
      S_EXEC: begin
        case (req_kind)
          KIND_PUSH_BACK:                 off = count;
          KIND_POP_BACK:                  off = count - CW'(1);
          KIND_READ_AT, KIND_REMOVE_AT:   off = CW'(req_pos);
          default:                        off = '0;
        endcase
      end
      S_SCAN, S_RMV0: off = idx_p1;
      S_SHIFT:        off = idx_p2;
      default:        off = '0;
    endcase
  end

  assign slot = slot_of(front, off);

  always_comb begin
    state_next      = state;
    front_next      = front;
    count_next      = count;
    idx_next        = idx;
    hold_addr_next  = hold_addr;
    res_status_next = res_status;
    res_data_next   = res_data;
    res_found_next  = res_found;
    wr_en           = 1'b0;
    wr_addr         = slot;
    wr_data         = req_key;
    rd_en           = 1'b0;

    case (state)
      S_IDLE: begin
        if (in_valid) begin
          res_status_next = STATUS_OK;
          res_data_next   = '0;
          res_found_next  = '0;
          state_next      = S_EXEC;
        end
      end
      S_EXEC: begin
        state_next = S_DONE;
        case (req_kind)
          KIND_PUSH_FRONT, KIND_PUSH_BACK: begin
            if (is_full) begin
              res_status_next = STATUS_FULL;
            end else begin
              wr_en      = 1'b1;
              count_next = count + CW'(1);
              if (req_kind == KIND_PUSH_FRONT) begin
                wr_addr    = front_dec;
                front_next = front_dec;
              end
            end
          end
          KIND_POP_FRONT: begin
            if (is_empty) begin
              res_status_next = STATUS_EMPTY;
            end else begin
              rd_en      = 1'b1;
              front_next = front_inc;
              count_next = count - CW'(1);
              state_next = S_RDATA;
            end
          end
          KIND_POP_BACK: begin
            if (is_empty) begin
              res_status_next = STATUS_EMPTY;
            end else begin
              rd_en      = 1'b1;
              count_next = count - CW'(1);
              state_next = S_RDATA;
            end
          end
          KIND_FIND: begin
            res_status_next = STATUS_EMPTY;
            if (!is_empty) begin
              rd_en      = 1'b1;
              idx_next   = '0;
              state_next = S_SCAN;
            end
          end
          KIND_READ_AT: begin
            if (pos_out) begin
              res_status_next = STATUS_RANGE;
            end else begin
              rd_en      = 1'b1;
              state_next = S_RDATA;
            end
          end
          KIND_REMOVE_AT: begin
            if (pos_out) begin
              res_status_next = STATUS_RANGE;
            end else begin
              rd_en      = 1'b1;
              idx_next   = CW'(req_pos);
              state_next = S_RMV0;
            end
          end
          default: begin
            state_next = S_DONE;
          end
        endcase
      end
      S_RDATA: begin
        res_data_next = to_out(rd_data);
        state_next    = S_DONE;
      end
      S_SCAN: begin
        // rd_data holds entry idx; next read is already addressed at idx + 1
        if (rd_data == req_key) begin
          res_status_next = STATUS_OK;
          res_found_next  = FOUND_W'(idx);
          state_next      = S_DONE;
        end else if (idx_p1 >= count) begin
          state_next = S_DONE;
        end else begin
          rd_en    = 1'b1;
          idx_next = idx_p1;
        end
      end
      S_RMV0: begin
        res_data_next  = to_out(rd_data);
        hold_addr_next = rd_addr_q;
        if (idx_p1 < count) begin
          rd_en      = 1'b1;
          state_next = S_SHIFT;
        end else begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end
      S_SHIFT: begin
        // move entry idx + 1 into the slot of entry idx
        wr_en          = 1'b1;
        wr_addr        = hold_addr;
        wr_data        = rd_data;
        hold_addr_next = rd_addr_q;
        idx_next       = idx_p1;
        if (idx_p2 < count) begin
          rd_en = 1'b1;
        end else begin
          count_next = count - CW'(1);
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  bdq_store #(
    .DEPTH (CAPACITY),
    .WIDTH (VALUE_BITS),
    .AW    (IW)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (slot),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      front <= front_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      req_kind <= kind;
      req_key  <= value_wide[VALUE_BITS-1:0];
      req_pos  <= position;
    end
    if (rd_en) begin
      rd_addr_q <= slot;
    end
    idx        <= idx_next;
    hold_addr  <= hold_addr_next;
    res_status <= res_status_next;
    res_data   <= res_data_next;
    res_found  <= res_found_next;
    if (out_load) begin
      status   <= res_status;
      data_out <= res_data;
      found_at <= res_found;
      length   <= LEN_W'(count);
    end
  end

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("request accepted while busy");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_load && res_status == STATUS_FULL |-> is_full)
    else $error("full status without a full store");

  a_shift_in_range: assert property (@(posedge clk) disable iff (rst)
    state == S_SHIFT |-> idx_p1 < count)
    else $error("shift past the last entry");
`endif

endmodule

[hw/rtl/bdq_store.sv]
// ring store: one write port, one read port with registered read data
module bdq_store #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 32,
  parameter int AW    = 4
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
